/* src/tdcprf_pkg.sv */
// tdcprf_pkg: shared types and constants for the tdc pileup rejection filter
// no dependencies; used by tdcprf_anchor and tdc_pileup_rejection_filter
package tdcprf_pkg;

  // fixed widths of the interface fields
  localparam int unsigned FieldBits = 48;
  localparam int unsigned WinBits   = 20;
  localparam int unsigned IdxBits   = 2;

  // request codes
  localparam logic REQ_HIT = 1'b0;
  localparam logic REQ_EOE = 1'b1;

  // configuration register indexes
  localparam logic [IdxBits-1:0] REG_PILEUP_EN = 2'd0;
  localparam logic [IdxBits-1:0] REG_DP_TICKS  = 2'd1;
  localparam logic [IdxBits-1:0] REG_PU_TICKS  = 2'd2;

  // register reset values
  localparam logic [WinBits-1:0] DP_TICKS_RST = 20'd2000;
  localparam logic [WinBits-1:0] PU_TICKS_RST = 20'd80000;

  // configuration as seen by the decision logic
  typedef struct packed {
    logic               pileup_en;
    logic [WinBits-1:0] dp_ticks;
    logic [WinBits-1:0] pu_ticks;
  } cfg_t;

endpackage

/* src/tdcprf_anchor.sv */
// tdcprf_anchor: anchor hit register and the per-item keep/drop decision
// depends on tdcprf_pkg
module tdcprf_anchor #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 req_type_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  tdcprf_pkg::cfg_t     cfg_i,
  output logic                 emit_o,
  output logic [TIME_BITS-1:0] emit_time_o
);

  logic [TIME_BITS-1:0] anchor_time_q, anchor_time_d;
  logic                 anchor_valid_q, anchor_valid_d;
  logic                 anchor_piled_q, anchor_piled_d;
  logic [TIME_BITS-1:0] hit_gap;
  logic                 in_dp, in_pu;

  // distance from anchor, saturating to zero for an earlier hit
  assign hit_gap = (time_i >= anchor_time_q) ? (time_i - anchor_time_q) : '0;
  assign in_dp   = 64'(hit_gap) <= 64'(cfg_i.dp_ticks);
  assign in_pu   = 64'(hit_gap) <= 64'(cfg_i.pu_ticks);

  // decision and next anchor state
  always_comb begin
    anchor_time_d  = anchor_time_q;
    anchor_valid_d = anchor_valid_q;
    anchor_piled_d = anchor_piled_q;
    emit_o         = 1'b0;
    emit_time_o    = time_i;
    if (req_type_i == tdcprf_pkg::REQ_EOE) begin
      // end of event flushes a clean pending anchor
      emit_o         = cfg_i.pileup_en && anchor_valid_q && !anchor_piled_q;
      emit_time_o    = anchor_time_q;
      anchor_valid_d = 1'b0;
      anchor_piled_d = 1'b0;
    end else if (!anchor_valid_q) begin
      // first hit becomes the anchor
      anchor_time_d  = time_i;
      anchor_valid_d = 1'b1;
      anchor_piled_d = 1'b0;
      emit_o         = !cfg_i.pileup_en;
    end else if (in_dp) begin
      // double pulse, dropped
    end else if (!cfg_i.pileup_en) begin
      anchor_time_d  = time_i;
      anchor_piled_d = 1'b0;
      emit_o         = 1'b1;
    end else if (in_pu) begin
      anchor_piled_d = 1'b1;
    end else begin
      // hit beyond the window proves the old anchor clean unless piled
      emit_o         = !anchor_piled_q;
      emit_time_o    = anchor_time_q;
      anchor_time_d  = time_i;
      anchor_piled_d = 1'b0;
    end
  end

  // anchor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_valid_q <= 1'b0;
      anchor_piled_q <= 1'b0;
    end else if (step_i) begin
      anchor_valid_q <= anchor_valid_d;
      anchor_piled_q <= anchor_piled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      anchor_time_q <= anchor_time_d;
    end
  end

endmodule

/* src/tdc_pileup_rejection_filter.sv */
// tdc_pileup_rejection_filter: top level, input stage, config registers, result stage
// depends on tdcprf_pkg and tdcprf_anchor
//
//   channel   signals                          direction   role
//   in        in_valid/ready, req_type, hit    sink        hits and end of event
//   out       out_valid/ready, kept_time       source      surviving hits
//   cfg       cfg_we, cfg_idx, cfg_wdata       sink        register writes
//
// one item per cycle sustained while the result is not stalled; an item passes from the
// input register to the result register, the anchor compare runs between input and result registers
// items that give no result leave the input stage without using the result slot
// reset clears the anchor and both stages and restores the register defaults
// a stalled result holds the input stage; one more item waits there meanwhile
module tdc_pileup_rejection_filter #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [tdcprf_pkg::FieldBits-1:0]   hit_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tdcprf_pkg::FieldBits-1:0]   kept_time_o,
  input  logic                               cfg_we_i,
  input  logic [tdcprf_pkg::IdxBits-1:0]     cfg_idx_i,
  input  logic [tdcprf_pkg::WinBits-1:0]     cfg_wdata_i
);

  tdcprf_pkg::cfg_t     cfg_q;
  logic                 in_valid_q;
  logic                 req_type_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 out_valid_q;
  logic [tdcprf_pkg::FieldBits-1:0] kept_time_q;
  logic                 advance;
  logic                 emit;
  logic [TIME_BITS-1:0] emit_time;
  logic [63:0]          hit_wide;
  logic [63:0]          emit_wide;

  // timestamps taken modulo 2^TIME_BITS
  assign hit_wide  = 64'(hit_time_i);
  assign emit_wide = 64'(emit_time);

  // input stage moves on whenever the result slot is free or being freed
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pileup_en <= 1'b0;
      cfg_q.dp_ticks  <= tdcprf_pkg::DP_TICKS_RST;
      cfg_q.pu_ticks  <= tdcprf_pkg::PU_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdcprf_pkg::REG_PILEUP_EN: cfg_q.pileup_en <= cfg_wdata_i[0];
        tdcprf_pkg::REG_DP_TICKS:  cfg_q.dp_ticks  <= cfg_wdata_i;
        tdcprf_pkg::REG_PU_TICKS:  cfg_q.pu_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q <= req_type_i;
      time_q     <= hit_wide[TIME_BITS-1:0];
    end
  end

  // anchor and decision
  tdcprf_anchor #(
    .TIME_BITS (TIME_BITS)
  ) u_anchor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_type_i  (req_type_q),
    .time_i      (time_q),
    .cfg_i       (cfg_q),
    .emit_o      (emit),
    .emit_time_o (emit_time)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kept_time_q <= emit_wide[tdcprf_pkg::FieldBits-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kept_time_o = kept_time_q;

endmodule

/* src/tdcprf_checker.sv */
// tdcprf_checker: port level checks on the tdc pileup rejection filter
// depends on tdcprf_pkg; attached to the top level by the bind below
module tdcprf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [tdcprf_pkg::FieldBits-1:0] kept_time_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kept_time_o))
    else $error("result changed while stalled");

  // an empty result slot never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no result pending");

  // a fresh result comes from an input transfer that passed through the input stage
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

endmodule

bind tdc_pileup_rejection_filter tdcprf_checker u_tdcprf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kept_time_o (kept_time_o)
);

/* tb/tdc_pileup_rejection_filter_tb.sv */
`timescale 1ns / 100ps
// tdc_pileup_rejection_filter_tb: self-checking bench for the tdc pileup rejection filter
// depends on tdcprf_pkg and tdc_pileup_rejection_filter; holds its own model of the filter

module tdc_pileup_rejection_filter_tb;

  localparam int unsigned TimeBits = 48;
  localparam int unsigned TsBits = tdcprf_pkg::FieldBits;
  localparam int unsigned WinW = tdcprf_pkg::WinBits;
  localparam logic [tdcprf_pkg::IdxBits-1:0] REG_SPARE = 2'd3;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned PipeSettle = 4;
  localparam int unsigned MaxPrints = 30;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 175;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              req_type_i;
  logic [TsBits-1:0]                 hit_time_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [TsBits-1:0]                 kept_time_o;
  logic                              cfg_we_i;
  logic [tdcprf_pkg::IdxBits-1:0]    cfg_idx_i;
  logic [WinW-1:0]                   cfg_wdata_i;

  // model copy of the registers and of the anchor
  tdcprf_pkg::cfg_t     mdl_cfg;
  logic [TsBits-1:0]    anchor_ts;
  logic                 anchor_held;
  logic                 anchor_piled;

  // kept timestamps still owed by the block, oldest first
  logic [TsBits-1:0]    kept_ts_q[$];
  logic [TsBits-1:0]    last_hit_ts;
  int unsigned          err_cnt;
  int unsigned          items_sent;
  int unsigned          idle_cycles;
  bit                   send_steady;
  bit                   ready_steady;

  tdc_pileup_rejection_filter #(
    .TIME_BITS(TimeBits)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .hit_time_i  (hit_time_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kept_time_o (kept_time_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // filter model: one transfer in, returns 1 when a kept timestamp comes out
  function automatic bit filter_predict(input logic req, input logic [TsBits-1:0] ts,
                                        output logic [TsBits-1:0] kept);
    logic [TsBits-1:0] span;
    bit                emit;
    emit = 1'b0;
    kept = '0;
    if (req == tdcprf_pkg::REQ_EOE) begin
      // flush a clean pending anchor, then forget it in either mode
      if (mdl_cfg.pileup_en && anchor_held && !anchor_piled) begin
        kept = anchor_ts;
        emit = 1'b1;
      end
      anchor_held  = 1'b0;
      anchor_piled = 1'b0;
      anchor_ts    = '0;
    end else if (!anchor_held) begin
      // first hit of the event becomes the anchor
      anchor_ts    = ts;
      anchor_held  = 1'b1;
      anchor_piled = 1'b0;
      if (!mdl_cfg.pileup_en) begin
        kept = ts;
        emit = 1'b1;
      end
    end else begin
      // distance saturates at zero for a hit earlier than the anchor
      span = (ts >= anchor_ts) ? ts - anchor_ts : '0;
      if (span <= TsBits'(mdl_cfg.dp_ticks)) begin
        emit = 1'b0;
      end else if (!mdl_cfg.pileup_en) begin
        anchor_ts    = ts;
        anchor_piled = 1'b0;
        kept         = ts;
        emit         = 1'b1;
      end else if (span <= TsBits'(mdl_cfg.pu_ticks)) begin
        anchor_piled = 1'b1;
      end else begin
        if (!anchor_piled) begin
          kept = anchor_ts;
          emit = 1'b1;
        end
        anchor_ts    = ts;
        anchor_piled = 1'b0;
      end
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrints) $display("%0t ns mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [TsBits-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TsBits-1:0];
  endfunction

  // idle stretch, mostly short with the odd long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // next hit, placed around the window edges relative to the anchor or last hit
  function automatic logic [TsBits-1:0] next_hit_ts();
    logic [TsBits-1:0] base;
    logic [TsBits-1:0] dp;
    logic [TsBits-1:0] pu;
    logic [TsBits-1:0] delta;
    dp   = TsBits'(mdl_cfg.dp_ticks);
    pu   = TsBits'(mdl_cfg.pu_ticks);
    base = (anchor_held && $urandom_range(0, 1) == 1) ? anchor_ts : last_hit_ts;
    case ($urandom_range(0, 11))
      0:       delta = '0;
      1:       delta = dp;
      2:       delta = dp + TsBits'(1);
      3:       delta = pu;
      4:       delta = pu + TsBits'(1);
      5:       delta = TsBits'($urandom_range(0, 32'(dp)));
      6:       delta = (pu > dp) ? TsBits'($urandom_range(32'(dp) + 1, 32'(pu)))
                                 : dp + TsBits'(1);
      7, 8:    delta = pu + TsBits'(1) + TsBits'($urandom_range(0, 200000));
      9:       delta = rand_ts() >> $urandom_range(4, 40);
      10:      return base - TsBits'($urandom_range(1, 5000));
      default: delta = dp + TsBits'(1) + TsBits'($urandom_range(0, 3));
    endcase
    return base + delta;
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_item(input logic req, input logic [TsBits-1:0] ts);
    logic [TsBits-1:0] kept;
    int unsigned       gap;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    hit_time_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    if (filter_predict(req, ts, kept)) kept_ts_q.push_back(kept);
    if (req == tdcprf_pkg::REQ_HIT) last_hit_ts = ts;
    items_sent++;
    @(negedge clk_i);
    gap = (!send_steady && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // hold off the sender until every owed result is out and the pipe has settled
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (kept_ts_q.size() != 0) @(negedge clk_i);
    repeat (PipeSettle) @(negedge clk_i);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(input logic [tdcprf_pkg::IdxBits-1:0] idx,
                           input logic [WinW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      tdcprf_pkg::REG_PILEUP_EN: mdl_cfg.pileup_en = data[0];
      tdcprf_pkg::REG_DP_TICKS:  mdl_cfg.dp_ticks  = data;
      tdcprf_pkg::REG_PU_TICKS:  mdl_cfg.pu_ticks  = data;
      default:                   ;
    endcase
    @(negedge clk_i);
  endtask

  // full register set, written while idle; the spare index goes last and must not land
  task automatic apply_config(input logic en, input logic [WinW-1:0] dp,
                              input logic [WinW-1:0] pu);
    logic [WinW-1:0] en_word;
    wait_results_drained();
    en_word    = WinW'($urandom);
    en_word[0] = en;
    write_reg(tdcprf_pkg::REG_PILEUP_EN, en_word);
    write_reg(tdcprf_pkg::REG_DP_TICKS, dp);
    write_reg(tdcprf_pkg::REG_PU_TICKS, pu);
    write_reg(REG_SPARE, WinW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // one event of random content, now and then broken or just noise
  task automatic send_random_event();
    int unsigned r;
    int unsigned n_hits;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_item(tdcprf_pkg::REQ_EOE, rand_ts());
      return;
    end
    if (r < 60) last_hit_ts = rand_ts();
    n_hits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    repeat (n_hits) send_item(tdcprf_pkg::REQ_HIT, next_hit_ts());
    if ($urandom_range(0, 9) != 0) send_item(tdcprf_pkg::REQ_EOE, rand_ts());
  endtask

  // reset register values, plain mode: immediate emit, double pulse edge, early hit
  task automatic test_plain_defaults();
    send_item(tdcprf_pkg::REQ_HIT, '0);
    send_item(tdcprf_pkg::REQ_HIT, 48'd2000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd2001);
    send_item(tdcprf_pkg::REQ_HIT, 48'd100);
    send_item(tdcprf_pkg::REQ_EOE, '1);
    send_item(tdcprf_pkg::REQ_EOE, '0);
    send_item(tdcprf_pkg::REQ_HIT, '1);
    send_item(tdcprf_pkg::REQ_EOE, 48'h5555_5555_5555);
  endtask

  // pileup mode: window edges, piled anchor replaced, clean anchor out, flush at end of event
  task automatic test_pileup_windows();
    apply_config(1'b1, tdcprf_pkg::DP_TICKS_RST, tdcprf_pkg::PU_TICKS_RST);
    send_item(tdcprf_pkg::REQ_HIT, 48'd1000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd3000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd81000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd200000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd280001);
    send_item(tdcprf_pkg::REQ_EOE, 48'hAAAA_AAAA_AAAA);
    send_item(tdcprf_pkg::REQ_HIT, 48'd5);
    send_item(tdcprf_pkg::REQ_HIT, 48'd2006);
    send_item(tdcprf_pkg::REQ_EOE, '0);
  endtask

  // double pulse window wider than pileup, mode switch with an anchor pending, widest windows
  task automatic test_overlap_and_mode_change();
    apply_config(1'b1, 20'd50000, 20'd1000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd10);
    send_item(tdcprf_pkg::REQ_HIT, 48'd40000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd60011);
    apply_config(1'b0, 20'd50000, 20'd1000);
    send_item(tdcprf_pkg::REQ_HIT, 48'd60012);
    send_item(tdcprf_pkg::REQ_HIT, 48'd200000);
    send_item(tdcprf_pkg::REQ_EOE, '1);
    apply_config(1'b1, '1, '1);
    send_item(tdcprf_pkg::REQ_HIT, '1);
    send_item(tdcprf_pkg::REQ_EOE, '0);
  endtask

  // random events over a series of register settings, extremes included
  task automatic test_random_traffic();
    int unsigned     phase;
    int unsigned     stop_at;
    bit              paused;
    logic [WinW-1:0] dp;
    logic [WinW-1:0] pu;
    paused = 1'b0;
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: apply_config(1'b0, tdcprf_pkg::DP_TICKS_RST, tdcprf_pkg::PU_TICKS_RST);
        1: apply_config(1'b1, tdcprf_pkg::DP_TICKS_RST, tdcprf_pkg::PU_TICKS_RST);
        2: apply_config(1'b1, '0, '0);
        3: apply_config(1'b1, '1, '1);
        4: begin
          dp = WinW'($urandom_range(1000, 20000));
          pu = WinW'($urandom_range(0, 32'(dp) - 1));
          apply_config(1'b1, dp, pu);
        end
        5: apply_config(1'b0, '0, '1);
        6: apply_config(1'b1, WinW'($urandom_range(0, 50)), WinW'($urandom_range(0, 300)));
        default: begin
          apply_config(1'($urandom_range(0, 1)), WinW'($urandom), WinW'($urandom));
        end
      endcase
      send_steady  = (phase == 2);
      ready_steady = (phase == 6);
      stop_at = items_sent + PhaseItems;
      while (items_sent < stop_at) begin
        send_random_event();
        // sender pause until the block has caught up
        if (phase == 1 && !paused && items_sent + PhaseItems / 2 > stop_at) begin
          wait_results_drained();
          paused = 1'b1;
        end
      end
    end
    send_steady  = 1'b0;
    ready_steady = 1'b0;
  endtask

  // receiver back-pressure
  initial begin : ready_driver
    int unsigned hold;
    out_ready_i = 1'b0;
    hold        = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (ready_steady || !out_ready_i) begin
        out_ready_i <= 1'b1;
        hold = ready_steady ? 0 : $urandom_range(0, 12);
      end else begin
        out_ready_i <= 1'b0;
        hold = idle_len() - 1;
      end
    end
  end

  // compare each output transfer with the oldest owed timestamp
  always @(posedge clk_i) begin : check_results
    logic [TsBits-1:0] exp_ts;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (kept_ts_q.size() == 0) begin
        report_mismatch($sformatf("kept_time %0h with nothing owed", kept_time_o));
      end else begin
        exp_ts = kept_ts_q.pop_front();
        if (kept_time_o !== exp_ts)
          report_mismatch($sformatf("kept_time %0h, wanted %0h", kept_time_o, exp_ts));
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tdc_pileup_rejection_filter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin : main_seq
    int unsigned drain_cycles;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = tdcprf_pkg::REQ_HIT;
    hit_time_i   = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = tdcprf_pkg::REG_PILEUP_EN;
    cfg_wdata_i  = '0;
    send_steady  = 1'b0;
    ready_steady = 1'b0;
    mdl_cfg.pileup_en = 1'b0;
    mdl_cfg.dp_ticks  = tdcprf_pkg::DP_TICKS_RST;
    mdl_cfg.pu_ticks  = tdcprf_pkg::PU_TICKS_RST;
    anchor_ts    = '0;
    anchor_held  = 1'b0;
    anchor_piled = 1'b0;
    last_hit_ts  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_plain_defaults();
    test_pileup_windows();
    test_overlap_and_mode_change();
    test_random_traffic();

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (kept_ts_q.size() != 0 && drain_cycles < DrainLimit) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(negedge clk_i);
    if (kept_ts_q.size() != 0)
      report_mismatch($sformatf("%0d kept times never came out", kept_ts_q.size()));

    if (err_cnt == 0) begin
      $display("tdc_pileup_rejection_filter test passed");
    end else begin
      $display("tdc_pileup_rejection_filter test failed");
    end
    $finish;
  end

endmodule
